@@ rtl/core/mexp_pkg.sv @@
// Shared constants for the modular exponentiation pipeline.
package mexp_pkg;
  localparam int unsigned WORD_BITS_DEF = 32;
  localparam int unsigned EXP_RESET     = 65537;
  localparam int unsigned REG_IDX_BITS  = 1;
  localparam logic [REG_IDX_BITS-1:0] REG_EXPONENT = 1'b0;
  localparam logic [REG_IDX_BITS-1:0] REG_MODULUS  = 1'b1;
endpackage

@@ rtl/core/mexp_reduce.sv @@
// Pipelined restoring reduction of the base modulo n, one bit per stage.
module mexp_reduce #(
  parameter int unsigned WORD_BITS = mexp_pkg::WORD_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic [WORD_BITS-1:0] mod_i,
  input  logic                 vld_i,
  input  logic [WORD_BITS-1:0] base_i,
  output logic                 vld_o,
  output logic [WORD_BITS-1:0] rem_o
);
  logic                 vld_q [WORD_BITS];
  logic [WORD_BITS-1:0] rem_q [WORD_BITS];
  logic [WORD_BITS-1:0] sh_q  [WORD_BITS];

  for (genvar s = 0; s < WORD_BITS; s++) begin : g_stage
    logic                 vld_in;
    logic [WORD_BITS-1:0] rem_in;
    logic [WORD_BITS-1:0] sh_in;
    logic [WORD_BITS:0]   trial;
    logic [WORD_BITS-1:0] rem_d;
    if (s == 0) begin : g_first
      assign vld_in = vld_i;
      assign rem_in = '0;
      assign sh_in  = base_i;
    end else begin : g_next
      assign vld_in = vld_q[s-1];
      assign rem_in = rem_q[s-1];
      assign sh_in  = sh_q[s-1];
    end
    // Shift in the next base bit, subtract n where it fits.
    always_comb begin
      trial = {rem_in, sh_in[WORD_BITS-1]};
      if (trial >= {1'b0, mod_i}) begin
        trial = trial - {1'b0, mod_i};
      end
      rem_d = trial[WORD_BITS-1:0];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_d;
        sh_q[s]  <= {sh_in[WORD_BITS-2:0], 1'b0};
      end
    end
  end

  assign vld_o = vld_q[WORD_BITS-1];
  assign rem_o = rem_q[WORD_BITS-1];
endmodule

@@ rtl/core/mexp_mulmod.sv @@
// Pipelined shift-and-add modular multiplier, one multiplier bit per stage.
module mexp_mulmod #(
  parameter int unsigned WORD_BITS = mexp_pkg::WORD_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic [WORD_BITS-1:0] mod_i,
  input  logic                 vld_i,
  input  logic [WORD_BITS-1:0] a_i,
  input  logic [WORD_BITS-1:0] b_i,
  input  logic [WORD_BITS-1:0] bas_i,
  output logic                 vld_o,
  output logic [WORD_BITS-1:0] prod_o,
  output logic [WORD_BITS-1:0] bas_o
);
  logic                 vld_q [WORD_BITS];
  logic [WORD_BITS-1:0] acc_q [WORD_BITS];
  logic [WORD_BITS-1:0] opa_q [WORD_BITS];
  logic [WORD_BITS-1:0] opb_q [WORD_BITS];
  logic [WORD_BITS-1:0] bas_q [WORD_BITS];

  function automatic logic [WORD_BITS-1:0] add_mod(input logic [WORD_BITS-1:0] x,
                                                   input logic [WORD_BITS-1:0] y,
                                                   input logic [WORD_BITS-1:0] m);
    logic [WORD_BITS:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[WORD_BITS-1:0];
  endfunction

  for (genvar s = 0; s < WORD_BITS; s++) begin : g_stage
    logic                 vld_in;
    logic [WORD_BITS-1:0] acc_in;
    logic [WORD_BITS-1:0] opa_in;
    logic [WORD_BITS-1:0] opb_in;
    logic [WORD_BITS-1:0] bas_in;
    logic [WORD_BITS-1:0] dbl;
    logic [WORD_BITS-1:0] acc_d;
    if (s == 0) begin : g_first
      assign vld_in = vld_i;
      assign acc_in = '0;
      assign opa_in = a_i;
      assign opb_in = b_i;
      assign bas_in = bas_i;
    end else begin : g_next
      assign vld_in = vld_q[s-1];
      assign acc_in = acc_q[s-1];
      assign opa_in = opa_q[s-1];
      assign opb_in = opb_q[s-1];
      assign bas_in = bas_q[s-1];
    end
    // Double the partial sum, then add the multiplicand on a set bit.
    always_comb begin
      dbl   = add_mod(acc_in, acc_in, mod_i);
      acc_d = opb_in[WORD_BITS-1] ? add_mod(dbl, opa_in, mod_i) : dbl;
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[s] <= acc_d;
        opa_q[s] <= opa_in;
        opb_q[s] <= {opb_in[WORD_BITS-2:0], 1'b0};
        bas_q[s] <= bas_in;
      end
    end
  end

  assign vld_o  = vld_q[WORD_BITS-1];
  assign prod_o = acc_q[WORD_BITS-1];
  assign bas_o  = bas_q[WORD_BITS-1];
endmodule

@@ rtl/core/modular_exponentiation.sv @@
// Top level of the pipelined modular exponentiation block.
// Returns base_value^exponent mod modulus for each item, one item accepted
// per cycle while the output is not stalled. The pipeline is a bit-serial
// reduction of the base, then one square and one conditional multiply per
// exponent bit, each a WORD_BITS-stage shift-and-add multiplier. A stall on
// the output freezes the whole pipeline. A modulus of one (or zero) yields 0.
// Write exponent and modulus only while no item is in flight; exponent resets
// to 65537 and modulus to 1.
module modular_exponentiation #(
  parameter int unsigned WORD_BITS = mexp_pkg::WORD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mexp_pkg::REG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [WORD_BITS-1:0]              cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [WORD_BITS-1:0]              base_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [WORD_BITS-1:0]              power_result_o
);
  localparam int unsigned NUM_MUL = 2 * WORD_BITS;

  logic [WORD_BITS-1:0] exponent_q;
  logic [WORD_BITS-1:0] modulus_q;
  logic                 en;

  logic                 vld [NUM_MUL+1];
  logic [WORD_BITS-1:0] acc [NUM_MUL+1];
  logic [WORD_BITS-1:0] bas [NUM_MUL+1];
  logic [WORD_BITS-1:0] red;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exponent_q <= WORD_BITS'(mexp_pkg::EXP_RESET);
      modulus_q  <= WORD_BITS'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mexp_pkg::REG_EXPONENT: exponent_q <= cfg_data_i;
        mexp_pkg::REG_MODULUS:  modulus_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Advance everywhere unless the finished item is held.
  assign en         = !vld[NUM_MUL] || out_ready_i;
  assign in_ready_o = en;

  mexp_reduce #(.WORD_BITS(WORD_BITS)) u_reduce (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .mod_i  (modulus_q),
    .vld_i  (in_valid_i),
    .base_i (base_value_i),
    .vld_o  (vld[0]),
    .rem_o  (red)
  );

  assign acc[0] = WORD_BITS'(1);
  assign bas[0] = red;

  for (genvar k = 0; k < NUM_MUL; k++) begin : g_mul
    logic [WORD_BITS-1:0] opb;
    if (k % 2 == 0) begin : g_sq
      assign opb = acc[k];
    end else begin : g_bit
      // Multiply by the base on a set exponent bit, by one otherwise.
      assign opb = exponent_q[WORD_BITS-1-k/2] ? bas[k] : WORD_BITS'(1);
    end
    mexp_mulmod #(.WORD_BITS(WORD_BITS)) u_mulmod (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .mod_i  (modulus_q),
      .vld_i  (vld[k]),
      .a_i    (acc[k]),
      .b_i    (opb),
      .bas_i  (bas[k]),
      .vld_o  (vld[k+1]),
      .prod_o (acc[k+1]),
      .bas_o  (bas[k+1])
    );
  end

  assign out_valid_o    = vld[NUM_MUL];
  assign power_result_o = (modulus_q <= WORD_BITS'(1)) ? '0 : acc[NUM_MUL];
endmodule
